// ===== rtl/core/edp_pkg.sv =====
`default_nettype none

package edp_pkg;

    // Defaults for the type code registers
    localparam logic [7:0] CMD_CODE_RST  = 8'd160;
    localparam logic [7:0] PUSH_CODE_RST = 8'd48;

    // Longest remaining-length field accepted before flagging an error
    localparam int MAX_LEN_BYTES_DEF = 4;

    // Remaining length is held to 28 bits (four groups of seven)
    localparam int LEN_W = 28;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_CMD_CODE  = 1'b0,
        REG_PUSH_CODE = 1'b1
    } t_reg_idx;

    // Field tags attached to every byte
    typedef enum logic [2:0] {
        TAG_TYPE   = 3'd0,
        TAG_LEN    = 3'd1,
        TAG_IDLEN  = 3'd2,
        TAG_ID     = 3'd3,
        TAG_CMDLEN = 3'd4,
        TAG_CMD    = 3'd5,
        TAG_PUSH   = 3'd6,
        TAG_OTHER  = 3'd7
    } t_tag;

    // One result per received byte
    typedef struct packed {
        logic [7:0]  data_byte;
        t_tag        field_tag;
        logic [31:0] field_value;
        logic        value_valid;
        logic        end_of_packet;
        logic        length_error;
        logic        subfield_overrun;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/edp_frame_receiver.sv =====
`default_nettype none

// Byte-stream deframer for packets made of a type byte, a 1 to
// MAX_LENGTH_BYTES byte base-128 remaining length (low group first, bit 7
// continues) and a payload. Every accepted byte gives exactly one output
// request carrying the byte, its field tag, a decoded length value on the
// last byte of a length field, end of packet on tlast and error flags.
// Command and push type codes are set via the write port (index 0 and 1);
// the user must write them only while the stream is idle; the block does
// not enforce it. One byte is accepted per clock cycle; a byte passes an
// input register, one pass of parser logic that updates the parser state,
// and an output register. Either side may stall at any time without loss.
module edp_frame_receiver #(
    parameter int MAX_LENGTH_BYTES = edp_pkg::MAX_LEN_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_addr,
    input  wire logic [7:0]  i_cfg_wdata,
    // input byte stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    // tagged output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [7:0] data_byte, [39:8] field_value,
                                             // [40] length_error,
                                             // [41] subfield_overrun, [47:42] zero
    output logic [3:0]       m_axis_tuser,   // [2:0] field_tag, [3] value_valid
    output logic             m_axis_tlast    // end_of_packet
);
    import edp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       l_advance;
    t_result    l_result;
    t_result    l_out;

    // Byte moves to the output register when that register is free or drains
    assign l_advance     = r_in_valid && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || l_advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    edp_parser #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (l_advance),
        .i_byte      (r_in_byte),
        .o_result    (l_result)
    );

    edp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (l_advance),
        .i_result (l_result),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_result (l_out)
    );

    // Output packing
    assign m_axis_tdata = {6'b0, l_out.subfield_overrun, l_out.length_error,
                           l_out.field_value, l_out.data_byte};
    assign m_axis_tuser = {l_out.value_valid, l_out.field_tag};
    assign m_axis_tlast = l_out.end_of_packet;

`ifndef ASSERT_OFF
    // a length error is reported on a length byte that ends nothing
    a_lerr_on_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && l_out.length_error) |->
            (l_out.field_tag == TAG_LEN && !l_out.end_of_packet && !l_out.value_valid))
        else $error("length error on a non-length byte");

    // decoded values only come with length-type fields
    a_value_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && l_out.value_valid) |->
            (l_out.field_tag == TAG_LEN || l_out.field_tag == TAG_IDLEN ||
             l_out.field_tag == TAG_CMDLEN))
        else $error("value valid on a non-length field");

    // overrun is only flagged at a packet end
    a_ovr_eop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && l_out.subfield_overrun) |-> l_out.end_of_packet)
        else $error("subfield overrun without end of packet");

    // stalled output request holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(l_out)))
        else $error("output changed while stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/edp_parser.sv =====
`default_nettype none

module edp_parser #(
    parameter int MAX_LENGTH_BYTES = edp_pkg::MAX_LEN_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [0:0]        i_cfg_addr,
    input  wire logic [7:0]        i_cfg_wdata,
    input  wire logic              i_fire,
    input  wire logic [7:0]        i_byte,
    output edp_pkg::t_result       o_result
);
    import edp_pkg::*;

    typedef enum logic [2:0] {
        PH_TYPE   = 3'd0,
        PH_LEN    = 3'd1,
        PH_IDLEN  = 3'd2,
        PH_ID     = 3'd3,
        PH_CMDLEN = 3'd4,
        PH_CMD    = 3'd5,
        PH_PUSH   = 3'd6,
        PH_OTHER  = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_CMD   = 2'd1,
        KIND_PUSH  = 2'd2
    } t_kind;

    localparam logic [2:0] LCNT_MAX = 3'(MAX_LENGTH_BYTES);

    logic [7:0]       r_cmd_code;
    logic [7:0]       r_push_code;
    t_phase           r_phase,  n_phase;
    t_kind            r_kind,   n_kind;
    logic [LEN_W-1:0] r_acc,    n_acc;
    logic [2:0]       r_lcnt,   n_lcnt;
    logic [LEN_W-1:0] r_pleft,  n_pleft;
    logic [31:0]      r_slen,   n_slen;
    logic [31:0]      r_sleft,  n_sleft;
    logic [2:0]       r_hcnt,   n_hcnt;

    logic [4:0]       l_shift;
    logic [LEN_W-1:0] l_acc_sum;
    logic [LEN_W-1:0] l_pl_dec;
    logic [31:0]      l_sl_dec;
    logic [2:0]       l_hcnt_inc;
    t_phase           l_after_id;

    // Next state and result for the byte in the input register
    always_comb begin
        n_phase  = r_phase;
        n_kind   = r_kind;
        n_acc    = r_acc;
        n_lcnt   = r_lcnt;
        n_pleft  = r_pleft;
        n_slen   = r_slen;
        n_sleft  = r_sleft;
        n_hcnt   = r_hcnt;

        o_result                  = '0;
        o_result.data_byte        = i_byte;
        o_result.field_tag        = TAG_OTHER;

        // 7 * count, from the low two bits of the count (below four by default)
        l_shift    = 5'({r_lcnt[1:0], 3'b000}) - 5'(r_lcnt[1:0]);
        l_acc_sum  = r_acc | (LEN_W'(i_byte[6:0]) << l_shift);
        l_pl_dec   = (r_pleft != '0) ? r_pleft - 1'b1 : '0;
        l_sl_dec   = (r_sleft != '0) ? r_sleft - 1'b1 : '0;
        l_hcnt_inc = r_hcnt + 1'b1;
        l_after_id = (r_kind == KIND_CMD) ? PH_CMDLEN : PH_PUSH;

        unique case (r_phase)
            PH_TYPE: begin
                o_result.field_tag = TAG_TYPE;
                if (i_byte == r_cmd_code) begin
                    n_kind = KIND_CMD;
                end else if (i_byte == r_push_code) begin
                    n_kind = KIND_PUSH;
                end else begin
                    n_kind = KIND_OTHER;
                end
                n_acc   = '0;
                n_lcnt  = '0;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                o_result.field_tag = TAG_LEN;
                if (r_lcnt >= LCNT_MAX) begin
                    // too many length bytes: drop back to a type byte
                    o_result.length_error = 1'b1;
                    n_acc   = '0;
                    n_lcnt  = '0;
                    n_phase = PH_TYPE;
                end else begin
                    n_acc  = l_acc_sum;
                    n_lcnt = r_lcnt + 1'b1;
                    if (!i_byte[7]) begin
                        o_result.field_value = 32'(l_acc_sum);
                        o_result.value_valid = 1'b1;
                        n_pleft = l_acc_sum;
                        n_hcnt  = '0;
                        n_slen  = '0;
                        n_sleft = '0;
                        if (l_acc_sum == '0) begin
                            o_result.end_of_packet = 1'b1;
                            n_phase = PH_TYPE;
                        end else if (r_kind == KIND_OTHER) begin
                            n_phase = PH_OTHER;
                        end else begin
                            n_phase = PH_IDLEN;
                        end
                    end
                end
            end
            default: begin
                // payload byte
                case (r_phase)
                    PH_IDLEN: begin
                        o_result.field_tag = TAG_IDLEN;
                        n_slen = 32'({r_slen[7:0], i_byte});
                        n_hcnt = l_hcnt_inc;
                        if (l_hcnt_inc >= 3'd2) begin
                            n_hcnt  = '0;
                            o_result.field_value = n_slen;
                            o_result.value_valid = 1'b1;
                            n_sleft = n_slen;
                            n_phase = (n_slen != '0) ? PH_ID : l_after_id;
                        end
                    end
                    PH_ID: begin
                        o_result.field_tag = TAG_ID;
                        n_sleft = l_sl_dec;
                        if (l_sl_dec == '0) begin
                            n_phase = l_after_id;
                        end
                    end
                    PH_CMDLEN: begin
                        o_result.field_tag = TAG_CMDLEN;
                        n_slen = {r_slen[23:0], i_byte};
                        n_hcnt = l_hcnt_inc;
                        if (l_hcnt_inc >= 3'd4) begin
                            n_hcnt  = '0;
                            o_result.field_value = n_slen;
                            o_result.value_valid = 1'b1;
                            n_sleft = n_slen;
                            n_phase = (n_slen != '0) ? PH_CMD : PH_OTHER;
                        end
                    end
                    PH_CMD: begin
                        o_result.field_tag = TAG_CMD;
                        n_sleft = l_sl_dec;
                        if (l_sl_dec == '0) begin
                            n_phase = PH_OTHER;
                        end
                    end
                    PH_PUSH: begin
                        o_result.field_tag = TAG_PUSH;
                    end
                    default: begin
                        o_result.field_tag = TAG_OTHER;
                        n_phase = PH_OTHER;
                    end
                endcase

                // payload count closes the packet
                n_pleft = l_pl_dec;
                if (l_pl_dec == '0) begin
                    o_result.end_of_packet = 1'b1;
                    if (n_phase == PH_IDLEN || n_phase == PH_ID ||
                        n_phase == PH_CMDLEN || n_phase == PH_CMD) begin
                        o_result.subfield_overrun = 1'b1;
                    end
                    n_phase = PH_TYPE;
                end
            end
        endcase
    end

    // Parser state and type code registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_code  <= CMD_CODE_RST;
            r_push_code <= PUSH_CODE_RST;
            r_phase     <= PH_TYPE;
            r_kind      <= KIND_OTHER;
            r_acc       <= '0;
            r_lcnt      <= '0;
            r_pleft     <= '0;
            r_slen      <= '0;
            r_sleft     <= '0;
            r_hcnt      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_addr))
                    REG_CMD_CODE:  r_cmd_code  <= i_cfg_wdata;
                    REG_PUSH_CODE: r_push_code <= i_cfg_wdata;
                endcase
            end
            if (i_fire) begin
                r_phase <= n_phase;
                r_kind  <= n_kind;
                r_acc   <= n_acc;
                r_lcnt  <= n_lcnt;
                r_pleft <= n_pleft;
                r_slen  <= n_slen;
                r_sleft <= n_sleft;
                r_hcnt  <= n_hcnt;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/edp_out_reg.sv =====
`default_nettype none

module edp_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire edp_pkg::t_result  i_result,
    input  wire logic              i_ready,
    output logic                   o_valid,
    output edp_pkg::t_result       o_result
);
    import edp_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Valid flag: set on load, cleared once the request is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire
